@@ hw/rtl/gswc_pkg.sv @@
// Shared widths, codes and constants of the gate schedule window check.
`default_nettype none

package gswc_pkg;

    // Fixed field widths of the request and result channels.
    localparam int TIME_W     = 64;
    localparam int INTV_W     = 32;
    localparam int CLASS_W    = 4;
    localparam int LIDX_W     = 6;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int STEP_W     = 6;

    // Gate mask: one bit per traffic class plus the best effort class.
    localparam int TRAFFIC_CLASSES = 8;
    localparam int MASK_W          = 9;
    localparam logic [MASK_W-1:0] MASK_ALL =
        MASK_W'((64'd1 << (TRAFFIC_CLASSES + 1)) - 64'd1);

    // Wide enough to compare entry counts and indexes up to 1024.
    localparam int EXT_W = 11;

    // Request commands.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES    = 2'd1;

    // Result status codes.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_ZERO_CYCLE = 1'b1;

    // Result of the shared adder: carry out and sum.
    typedef struct packed {
        logic              carry;
        logic [TIME_W-1:0] sum;
    } t_alu_res;

endpackage

`default_nettype wire

@@ hw/rtl/gate_schedule_window_check_core.sv @@
// Top level of the gate schedule window check: sequencer, shared adder and schedule RAM.
//
// The request channel (i_valid / o_ready) carries either a load command, which writes
// one schedule entry (gate mask and interval in ns) and gives no result, or a frame
// command with a timestamp and a traffic class. A frame gives one result on the result
// channel (o_valid / i_ready): window start, offset into the window, entry mask and
// index, whether the class gate is open, and a status. Frames at or before the base
// time give no result until the first frame after the base time has been seen.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes the base time (index 0)
// or the number of entries in use (index 1); it is always ready. The user must use it only
// while the block is idle; the block itself does not enforce this.
// A load is written while the block stays ready. A frame passes the base time check, then
// sums the N intervals in use when a load or a count write cleared the cached cycle length,
// checks the sum, forms the bit-serial remainder, walks the entries and forms the result;
// the sum and its check are skipped with a cached cycle length.
// One 64-bit adder and one RAM read port serve all steps; the block is not ready
// while a frame is in progress. Reset clears the started flag, the cycle length and the
// base time, sets the entry count to 1 and drops any pending result; the RAM keeps data.
// A result waits in the output register while the receiver stalls; the block takes the
// next request meanwhile, and a second result holds the sequencer until the first drains.
`default_nettype none

module gate_schedule_window_check_core
    import gswc_pkg::*;
#(
    parameter int SCHED_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request channel.
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_command,
    input  logic [LIDX_W-1:0]    i_load_index,
    input  logic [MASK_W-1:0]    i_load_gate_mask,
    input  logic [INTV_W-1:0]    i_load_interval,
    input  logic [TIME_W-1:0]    i_frame_time,
    input  logic [CLASS_W-1:0]   i_frame_class,
    // Result channel.
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [TIME_W-1:0]    o_window_start,
    output logic [INTV_W-1:0]    o_window_offset,
    output logic                 o_on_time,
    output logic [MASK_W-1:0]    o_current_mask,
    output logic [LIDX_W-1:0]    o_current_index,
    output logic                 o_status,
    // Configuration channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0]    i_cfg_data
);

    // Address width of the schedule RAM, index width able to hold the count
    // itself, and cycle length width (sum of SCHED_DEPTH 32-bit intervals).
    localparam int AW    = (SCHED_DEPTH > 1) ? $clog2(SCHED_DEPTH) : 1;
    localparam int IW    = $clog2(SCHED_DEPTH + 1);
    localparam int CYC_W = INTV_W + ((SCHED_DEPTH > 1) ? $clog2(SCHED_DEPTH) : 0);
    localparam int RAM_W = MASK_W + INTV_W;
    localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(SCHED_DEPTH);

    // Sequencer state codes.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIFF = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_WALK = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_ERR  = 3'd7;

    // Control state.
    logic [2:0]          r_state, n_state;
    logic                r_started, n_started;
    logic [CYC_W-1:0]    r_cyc, n_cyc;
    logic [TIME_W-1:0]   r_base, n_base;
    logic [IW-1:0]       r_count, n_count;
    logic                r_out_valid, n_out_valid;

    // Working registers of the current frame.
    logic [TIME_W-1:0]   r_ts, n_ts;
    logic [CLASS_W-1:0]  r_cls, n_cls;
    logic [TIME_W-1:0]   r_diff, n_diff;
    logic [CYC_W-1:0]    r_rem, n_rem;
    logic [STEP_W-1:0]   r_bit, n_bit;
    logic [IW-1:0]       r_idx, n_idx;

    // Result register.
    logic [TIME_W-1:0]   r_win_start, n_win_start;
    logic [INTV_W-1:0]   r_win_offset, n_win_offset;
    logic                r_on_time, n_on_time;
    logic [MASK_W-1:0]   r_cur_mask, n_cur_mask;
    logic [LIDX_W-1:0]   r_cur_index, n_cur_index;
    logic                r_status, n_status;

    // Shared adder.
    logic [TIME_W-1:0]   alu_a, alu_b;
    logic                alu_sub;
    t_alu_res            alu_res;

    // Schedule RAM and helpers.
    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [RAM_W-1:0]    ram_wdata, ram_rdata;
    logic [INTV_W-1:0]   rd_interval;
    logic [MASK_W-1:0]   rd_mask;
    logic [AW+LIDX_W-1:0] load_idx_ext;
    logic                load_in_range;
    logic                in_fire, cfg_fire, out_free;
    logic [IW-1:0]       idx_last;
    logic [CYC_W:0]      div_trial;
    logic [15:0]         mask_ext;
    logic [EXT_W-1:0]    cnt_ext, idx_ext;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_valid && o_ready;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    // The result register can take a new result when it is empty or being read.
    assign out_free    = !r_out_valid || i_ready;

    assign idx_last = r_count - IW'(1);

    // A load beyond the schedule depth is dropped.
    assign load_idx_ext  = (AW + LIDX_W)'(i_load_index);
    assign load_in_range = load_idx_ext < (AW + LIDX_W)'(SCHED_DEPTH);

    assign ram_we    = in_fire && (i_command == CMD_LOAD) && load_in_range;
    assign ram_waddr = load_idx_ext[AW-1:0];
    assign ram_wdata = {i_load_gate_mask & MASK_ALL, i_load_interval};
    // The RAM read is registered, so the next index is presented: the data of
    // the entry at r_idx is then valid in the same cycle as r_idx.
    assign ram_raddr = n_idx[AW-1:0];
    assign rd_interval = ram_rdata[INTV_W-1:0];
    assign rd_mask     = ram_rdata[RAM_W-1:INTV_W];

    gswc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SCHED_DEPTH)
    ) u_sched_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The one adder of the block: adds, or subtracts with the carry out meaning
    // "a is not below b".
    assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + {{TIME_W{1'b0}}, alu_sub};

    // One restoring division step: shift in the next dividend bit.
    assign div_trial = {r_rem, r_diff[TIME_W-1]};

    // Gate bit of the frame's class; classes past the mask read as shut.
    assign mask_ext = 16'(rd_mask);
    assign idx_ext  = EXT_W'(r_idx);
    assign cnt_ext  = EXT_W'(i_cfg_data[CNT_W-1:0]);

    always_comb begin
        n_state      = r_state;
        n_started    = r_started;
        n_cyc        = r_cyc;
        n_base       = r_base;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_ready;
        n_ts         = r_ts;
        n_cls        = r_cls;
        n_diff       = r_diff;
        n_rem        = r_rem;
        n_bit        = r_bit;
        n_idx        = r_idx;
        n_win_start  = r_win_start;
        n_win_offset = r_win_offset;
        n_on_time    = r_on_time;
        n_cur_mask   = r_cur_mask;
        n_cur_index  = r_cur_index;
        n_status     = r_status;
        alu_a        = '0;
        alu_b        = '0;
        alu_sub      = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_command == CMD_FRAME) begin
                        n_ts    = i_frame_time;
                        n_cls   = i_frame_class;
                        n_state = S_DIFF;
                    end else if (load_in_range) begin
                        // A new entry invalidates the cached cycle length.
                        n_cyc = '0;
                    end
                end
            end
            S_DIFF: begin
                alu_a = r_ts;
                alu_b = r_base;
                if (!r_started && (!alu_res.carry || (alu_res.sum == '0))) begin
                    n_state = S_IDLE;
                end else begin
                    n_started = 1'b1;
                    n_diff    = alu_res.sum;
                    n_idx     = '0;
                    n_rem     = '0;
                    n_bit     = '0;
                    if (r_cyc == '0) begin
                        n_state = S_SUM;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_SUM: begin
                alu_a   = TIME_W'(r_cyc);
                alu_b   = TIME_W'(rd_interval);
                alu_sub = 1'b0;
                n_cyc   = alu_res.sum[CYC_W-1:0];
                if (r_idx == idx_last) begin
                    n_state = S_CHK;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_CHK: begin
                n_rem = '0;
                n_bit = '0;
                if (r_cyc == '0) begin
                    n_state = S_ERR;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                alu_a  = TIME_W'(div_trial);
                alu_b  = TIME_W'(r_cyc);
                n_rem  = alu_res.carry ? alu_res.sum[CYC_W-1:0] : div_trial[CYC_W-1:0];
                n_diff = {r_diff[TIME_W-2:0], 1'b0};
                n_bit  = r_bit + STEP_W'(1);
                if (r_bit == '1) begin
                    n_idx   = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                alu_a = TIME_W'(r_rem);
                alu_b = TIME_W'(rd_interval);
                if (alu_res.carry && (r_idx != idx_last)) begin
                    n_rem = alu_res.sum[CYC_W-1:0];
                    n_idx = r_idx + IW'(1);
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                alu_a = r_ts;
                alu_b = TIME_W'(r_rem);
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_win_start  = alu_res.sum;
                    n_win_offset = r_rem[INTV_W-1:0];
                    n_on_time    = (r_cls <= CLASS_W'(TRAFFIC_CLASSES)) && mask_ext[r_cls];
                    n_cur_mask   = rd_mask;
                    n_cur_index  = idx_ext[LIDX_W-1:0];
                    n_status     = STATUS_OK;
                    n_state      = S_IDLE;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_win_start  = '0;
                    n_win_offset = '0;
                    n_on_time    = 1'b0;
                    n_cur_mask   = '0;
                    n_cur_index  = '0;
                    n_status     = STATUS_ZERO_CYCLE;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Register writes must arrive only while the sequencer is idle; the block does not enforce this.
        if (cfg_fire) begin
            if (i_cfg_index == CFG_START_TIME) begin
                n_base = i_cfg_data;
            end else if (i_cfg_index == CFG_ENTRIES) begin
                n_cyc = '0;
                if (cnt_ext == '0) begin
                    n_count = IW'(1);
                end else if (cnt_ext > MAX_EXT) begin
                    n_count = IW'(SCHED_DEPTH);
                end else begin
                    n_count = cnt_ext[IW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_cyc       <= '0;
            r_base      <= '0;
            r_count     <= IW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_cyc       <= n_cyc;
            r_base      <= n_base;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ts         <= n_ts;
        r_cls        <= n_cls;
        r_diff       <= n_diff;
        r_rem        <= n_rem;
        r_bit        <= n_bit;
        r_idx        <= n_idx;
        r_win_start  <= n_win_start;
        r_win_offset <= n_win_offset;
        r_on_time    <= n_on_time;
        r_cur_mask   <= n_cur_mask;
        r_cur_index  <= n_cur_index;
        r_status     <= n_status;
    end

    assign o_valid         = r_out_valid;
    assign o_window_start  = r_win_start;
    assign o_window_offset = r_win_offset;
    assign o_on_time       = r_on_time;
    assign o_current_mask  = r_cur_mask;
    assign o_current_index = r_cur_index;
    assign o_status        = r_status;

    // The walk never moves past the last entry in use.
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_idx < r_count))
        else $error("schedule walk index beyond entries in use");

    // The partial remainder stays below the divisor throughout the division.
    a_rem_below_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_cyc))
        else $error("partial remainder not below cycle length");

    // A window result is only formed with a nonzero cycle length.
    a_fin_nonzero_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_cyc != '0))
        else $error("window result with zero cycle length");

    // The started flag is only set by the base time check of a frame.
    a_started_from_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_started) |-> ($past(r_state) == S_DIFF))
        else $error("started flag set outside the base time check");

endmodule

`default_nettype wire

@@ hw/rtl/gswc_ram.sv @@
// Generic single write port RAM with a registered read port.
`default_nettype none

module gswc_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ tb/sv/gswc_window_monitor.sv @@
// Watches the request, result and configuration channels, predicts every result and compares.
module gswc_window_monitor
    import gswc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  logic                 i_command,
    input  logic [LIDX_W-1:0]    i_load_index,
    input  logic [MASK_W-1:0]    i_load_gate_mask,
    input  logic [INTV_W-1:0]    i_load_interval,
    input  logic [TIME_W-1:0]    i_frame_time,
    input  logic [CLASS_W-1:0]   i_frame_class,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  logic [TIME_W-1:0]    i_window_start,
    input  logic [INTV_W-1:0]    i_window_offset,
    input  logic                 i_on_time,
    input  logic [MASK_W-1:0]    i_current_mask,
    input  logic [LIDX_W-1:0]    i_current_index,
    input  logic                 i_status,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0]    i_cfg_data,
    output int                   o_pending,
    output int                   o_mismatches
);

    localparam int ENTRY_SLOTS = 64;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [INTV_W-1:0] offset;
        logic              on_time;
        logic [MASK_W-1:0] mask;
        logic [LIDX_W-1:0] index;
        logic              status;
    } t_window;

    logic [MASK_W-1:0] gate_masks [ENTRY_SLOTS];
    logic [INTV_W-1:0] intervals  [ENTRY_SLOTS];
    logic [37:0]       cycle_len;
    logic [TIME_W-1:0] sched_base;
    logic [CNT_W-1:0]  entries_reg;
    bit                started;
    t_window           pending_windows [$];
    int                mismatches;

    // Works out the window of one frame; returns 0 when the frame gives no result.
    function automatic bit predict_window(input logic [TIME_W-1:0] ts,
                                          input logic [CLASS_W-1:0] cls,
                                          output t_window w);
        int unsigned       n;
        int unsigned       k;
        logic [TIME_W-1:0] rem;
        logic [TIME_W-1:0] sum;
        w = '0;
        if (!started) begin
            if (ts <= sched_base)
                return 1'b0;
            started = 1'b1;
        end
        n = (entries_reg == 0) ? 1 : ((entries_reg > ENTRY_SLOTS) ? ENTRY_SLOTS : entries_reg);
        if (cycle_len == 0) begin
            sum = '0;
            for (k = 0; k < n; k++)
                sum += intervals[k];
            cycle_len = sum[37:0];
        end
        if (cycle_len == 0) begin
            w.status = STATUS_ZERO_CYCLE;
            return 1'b1;
        end
        rem = (ts - sched_base) % {26'd0, cycle_len};
        k = 0;
        while (k < n && rem >= {32'd0, intervals[k]}) begin
            rem -= intervals[k];
            k++;
        end
        if (k >= n)
            k = n - 1;
        w.start   = ts - rem;
        w.offset  = rem[INTV_W-1:0];
        w.on_time = (cls <= TRAFFIC_CLASSES) ? gate_masks[k][cls] : 1'b0;
        w.mask    = gate_masks[k];
        w.index   = k[LIDX_W-1:0];
        w.status  = STATUS_OK;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : track
        t_window got;
        t_window want;
        t_window fresh;
        if (!i_rst_n) begin
            sched_base  = '0;
            entries_reg = 7'd1;
            cycle_len   = '0;
            started     = 1'b0;
            pending_windows.delete();
        end else begin
            // Results leave before new requests enter, so a result is never
            // matched against a request taken at the same edge.
            if (i_res_valid && i_res_ready) begin
                got = '{i_window_start, i_window_offset, i_on_time,
                        i_current_mask, i_current_index, i_status};
                if (pending_windows.size() == 0) begin
                    if (mismatches < REPORT_MAX)
                        $display("unexpected result: start %h off %h on %b mask %h idx %0d st %b",
                                 got.start, got.offset, got.on_time, got.mask, got.index,
                                 got.status);
                    mismatches++;
                end else begin
                    want = pending_windows.pop_front();
                    if (got !== want) begin
                        if (mismatches < REPORT_MAX) begin
                            $display("mismatch expected: start %h off %h on %b mask %h idx %0d st %b",
                                     want.start, want.offset, want.on_time, want.mask,
                                     want.index, want.status);
                            $display("mismatch actual:   start %h off %h on %b mask %h idx %0d st %b",
                                     got.start, got.offset, got.on_time, got.mask,
                                     got.index, got.status);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_START_TIME) begin
                    sched_base = i_cfg_data;
                end else if (i_cfg_index == CFG_ENTRIES) begin
                    entries_reg = i_cfg_data[CNT_W-1:0];
                    cycle_len   = '0;
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_command == CMD_LOAD) begin
                    if (i_load_index < ENTRY_SLOTS) begin
                        gate_masks[i_load_index] = i_load_gate_mask & MASK_ALL;
                        intervals[i_load_index]  = i_load_interval;
                        cycle_len                = '0;
                    end
                end else if (predict_window(i_frame_time, i_frame_class, fresh)) begin
                    pending_windows.push_back(fresh);
                end
            end
        end
        o_pending    <= pending_windows.size();
        o_mismatches <= mismatches;
    end

endmodule

@@ tb/sv/tb_gate_schedule_window_check_core.sv @@
// Stimulus, clock, reset and verdict for the gate schedule window check core.
module tb_gate_schedule_window_check_core;
    import gswc_pkg::*;

    // The pause covers the longest frame with all 64 entries in use; the margin covers the
    // result register and the sequencer slot draining.
    localparam int DRAIN_CYCLES = 240;
    // The receiver holds off this long once, so the block fills and stalls requests.
    localparam int HOLD_CYCLES  = 700;
    // Longest legal stretch without any handshake is the hold plus a frame and a
    // drain pause; the limit is several times that.
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_PHASES = 9;

    // Register indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum int {SINK_OPEN, SINK_HALF, SINK_SPARSE} t_sink_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_command;
    logic [LIDX_W-1:0]    i_load_index;
    logic [MASK_W-1:0]    i_load_gate_mask;
    logic [INTV_W-1:0]    i_load_interval;
    logic [TIME_W-1:0]    i_frame_time;
    logic [CLASS_W-1:0]   i_frame_class;
    logic                 o_valid;
    logic                 i_ready;
    logic [TIME_W-1:0]    o_window_start;
    logic [INTV_W-1:0]    o_window_offset;
    logic                 o_on_time;
    logic [MASK_W-1:0]    o_current_mask;
    logic [LIDX_W-1:0]    o_current_index;
    logic                 o_status;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [TIME_W-1:0]    i_cfg_data;

    int pending_results;
    int mismatch_count;
    int quiet_cycles = 0;
    int burst_left   = 0;
    bit hold_request = 1'b0;
    bit loaded [64];
    int active_count = 1;

    gate_schedule_window_check_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_command        (i_command),
        .i_load_index     (i_load_index),
        .i_load_gate_mask (i_load_gate_mask),
        .i_load_interval  (i_load_interval),
        .i_frame_time     (i_frame_time),
        .i_frame_class    (i_frame_class),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_window_start   (o_window_start),
        .o_window_offset  (o_window_offset),
        .o_on_time        (o_on_time),
        .o_current_mask   (o_current_mask),
        .o_current_index  (o_current_index),
        .o_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    gswc_window_monitor u_monitor (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_ready      (o_ready),
        .i_command        (i_command),
        .i_load_index     (i_load_index),
        .i_load_gate_mask (i_load_gate_mask),
        .i_load_interval  (i_load_interval),
        .i_frame_time     (i_frame_time),
        .i_frame_class    (i_frame_class),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_window_start   (o_window_start),
        .i_window_offset  (o_window_offset),
        .i_on_time        (o_on_time),
        .i_current_mask   (o_current_mask),
        .i_current_index  (o_current_index),
        .i_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_pending        (pending_results),
        .o_mismatches     (mismatch_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The watchdog restarts its count on any handshake of any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_gate_schedule_window_check_core failed");
            $finish;
        end
    end

    // The result side stalls on its own pattern: segments that are always
    // ready, half ready or rarely ready, plus one long hold-off on request.
    initial begin : result_sink
        t_sink_mode mode;
        int         seg_left;
        bit         hold_done;
        mode      = SINK_OPEN;
        seg_left  = 0;
        hold_done = 1'b0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    mode     = t_sink_mode'($urandom_range(0, 2));
                    seg_left = $urandom_range(10, 150);
                end
                seg_left--;
                case (mode)
                    SINK_OPEN:  i_ready <= 1'b1;
                    SINK_HALF:  i_ready <= 1'($urandom_range(0, 1));
                    default:    i_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    function automatic logic [INTV_W-1:0] pick_interval();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom;
            2:       return $urandom_range(1, 32'h00FF_FFFF);
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    // Most frames land after the base time at every scale; some fall just
    // before it and some anywhere in the 64-bit range.
    function automatic logic [TIME_W-1:0] pick_frame_time(input logic [TIME_W-1:0] base);
        logic [TIME_W-1:0] span;
        span = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return span;
            1:       return base - TIME_W'($urandom_range(1, 1000));
            default: return base + (span >> $urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [CLASS_W-1:0] pick_class();
        if ($urandom_range(0, 4) == 0)
            return CLASS_W'($urandom_range(0, 15));
        return CLASS_W'($urandom_range(0, TRAFFIC_CLASSES));
    endfunction

    // Offers one request in the sender's burst pattern and returns at the
    // edge where it is accepted, with valid still high.
    task automatic send_request(input logic cmd, input logic [LIDX_W-1:0] idx,
                                input logic [MASK_W-1:0] mask,
                                input logic [INTV_W-1:0] intv,
                                input logic [TIME_W-1:0] ts,
                                input logic [CLASS_W-1:0] cls);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_command        <= cmd;
        i_load_index     <= idx;
        i_load_gate_mask <= mask;
        i_load_interval  <= intv;
        i_frame_time     <= ts;
        i_frame_class    <= cls;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // The frame fields of a load request and the load fields of a frame
    // request are filled with noise; the block must ignore them.
    task automatic load_entry(input logic [LIDX_W-1:0] idx, input logic [MASK_W-1:0] mask,
                              input logic [INTV_W-1:0] intv);
        send_request(CMD_LOAD, idx, mask, intv, {$urandom, $urandom},
                     CLASS_W'($urandom_range(0, 15)));
        loaded[idx] = 1'b1;
    endtask

    task automatic check_frame(input logic [TIME_W-1:0] ts, input logic [CLASS_W-1:0] cls);
        send_request(CMD_FRAME, LIDX_W'($urandom_range(0, 63)),
                     MASK_W'($urandom_range(0, 511)), $urandom, ts, cls);
    endtask

    // Every entry in use must hold a loaded value before a frame reads it.
    task automatic fill_entries();
        for (int k = 0; k < active_count; k++)
            if (!loaded[k])
                load_entry(LIDX_W'(k), MASK_W'($urandom_range(0, 511)), pick_interval());
    endtask

    // Waits until no result is owed, then lets the block finish any load or
    // early frame that gives no result.
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Leaves valid high so that back-to-back register writes need one assignment per edge.
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Writes both registers, sometimes an undecoded index too, and tracks the
    // entry count in effect. Upper bits of the count write are noise.
    task automatic configure(input logic [TIME_W-1:0] base, input logic [CNT_W-1:0] count);
        logic [TIME_W-1:0] count_word;
        count_word            = {$urandom, $urandom};
        count_word[CNT_W-1:0] = count;
        cfg_put(CFG_START_TIME, base);
        cfg_put(CFG_ENTRIES, count_word);
        if ($urandom_range(0, 2) == 0)
            cfg_put($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, {$urandom, $urandom});
        i_cfg_valid  <= 1'b0;
        active_count = (count == 0) ? 1 : ((count > 64) ? 64 : count);
    endtask

    initial begin : stimulus
        logic [TIME_W-1:0] base;
        logic [CNT_W-1:0]  count;
        int                items;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_command        <= CMD_LOAD;
        i_load_index     <= '0;
        i_load_gate_mask <= '0;
        i_load_interval  <= '0;
        i_frame_time     <= '0;
        i_frame_class    <= '0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= CFG_START_TIME;
        i_cfg_data       <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Frames at and before the base time give nothing until
        // the first later frame starts the schedule; with one zero entry the
        // cycle is empty and the status reports it, also for an early frame
        // once started, whose time since base wraps.
        configure(64'd1000, 7'd1);
        load_entry(6'd0, 9'h000, 32'd0);
        check_frame(64'd0, 4'd0);
        check_frame(64'd1000, 4'd0);
        check_frame(64'd1001, 4'd0);
        check_frame(64'd5, 4'd2);
        // One open entry: window edges, the best effort class, classes without
        // a gate bit, the largest time and an early frame.
        load_entry(6'd0, 9'h1FF, 32'd100);
        check_frame(64'd1000, 4'd0);
        check_frame(64'd1099, 4'd8);
        check_frame('1, 4'd9);
        check_frame(64'd999, 4'd15);
        // Largest interval and the highest entry index.
        load_entry(6'd0, 9'h000, 32'hFFFF_FFFF);
        check_frame(64'd1000 + 64'hFFFF_FFFE, 4'd3);
        load_entry(6'd63, 9'h155, 32'd7);
        // A zero-length middle entry must be skipped by the walk.
        load_entry(6'd1, 9'h0AA, 32'd0);
        load_entry(6'd2, 9'h101, 32'd50);
        wait_idle();
        configure(64'd1000, 7'd3);
        check_frame(64'd1000 + 64'hFFFF_FFFF + 64'd10, 4'd8);
        check_frame(64'd1000 + 64'hFFFF_FFFE, 4'd1);
        check_frame(64'd1000 + 64'hFFFF_FFFF + 64'd49, 4'd0);
        wait_idle();

        // Full schedule while the receiver holds off once for a long stretch:
        // the results back up and the request side must stall.
        configure(64'd0, 7'd64);
        fill_entries();
        hold_request = 1'b1;
        repeat (30) check_frame(pick_frame_time(64'd0), pick_class());
        wait_idle();

        // Random phases walk through entry counts at and beyond both ends and
        // base times at both extremes.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 5)
                0:       count = CNT_W'($urandom_range(0, 1));
                1:       count = ($urandom_range(0, 1) != 0) ? 7'd64
                                                             : CNT_W'($urandom_range(65, 127));
                2:       count = CNT_W'($urandom_range(1, 64));
                default: count = CNT_W'($urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 3))
                0:       base = '0;
                1:       base = '1;
                2:       base = {$urandom, $urandom};
                default: base = TIME_W'($urandom_range(0, 100000));
            endcase
            configure(base, count);
            fill_entries();
            items = $urandom_range(35, 50);
            repeat (items) begin
                if ($urandom_range(0, 4) == 0)
                    // Loads favor the entries in use so that the cycle length
                    // is cleared and summed again, sometimes to zero.
                    load_entry(LIDX_W'(($urandom_range(0, 1) != 0)
                                       ? $urandom_range(0, active_count - 1)
                                       : $urandom_range(0, 63)),
                               MASK_W'($urandom_range(0, 511)), pick_interval());
                else
                    check_frame(pick_frame_time(base), pick_class());
            end
            wait_idle();
        end

        if (mismatch_count == 0 && pending_results == 0)
            $display("tb_gate_schedule_window_check_core passed");
        else
            $display("tb_gate_schedule_window_check_core failed");
        $finish;
    end

endmodule
